/* rtl/cmc_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// CNF model checker. No dependencies.
package cmc_pkg;

   localparam int MAX_VARS = 4096;
   localparam int ADDR_W   = $clog2(MAX_VARS);
   localparam int CNT_W    = $clog2(MAX_VARS + 1);
   localparam int LIT_W    = 13;
   localparam int VAR_W    = 13;
   localparam int NUM_W    = 16;
   localparam int POL_W    = 2;

   localparam logic [NUM_W-1:0] NUM_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_CLAUSE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef logic [POL_W-1:0] pol_type;
   localparam pol_type POL_UNDEF = 2'd0;
   localparam pol_type POL_POS   = 2'd1;
   localparam pol_type POL_NEG   = 2'd2;

   typedef struct packed {
      logic accept;   // request taken, launch store read
      logic commit;   // apply evaluated request
      logic sweep;    // clearing pass step
   } cmd_type;

   typedef struct packed {
      logic stall;        // result pending but output register still full
      logic restart;      // held request is a clear
      logic sweep_done;   // last store entry being cleared
   } status_type;

endpackage

/* rtl/cmc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/cmc_ctrl.sv */
// Controller FSM: clearing pass, request acceptance and evaluation sequencing.
// Depends on cmc_pkg.
module cmc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cmc_pkg::status_type status,
   output cmc_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EVAL
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         ready_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_SWEEP: begin
               if (status.sweep_done) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EVAL;
                  ready_ff <= 1'b0;
               end
            end
            ST_EVAL: begin
               if (!status.stall) begin
                  if (status.restart) begin
                     state_ff <= ST_SWEEP;
                  end else begin
                     state_ff <= ST_IDLE;
                     ready_ff <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_SWEEP;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready  = ready_ff;
   assign cmd.accept = ready_ff && req_valid;
   assign cmd.commit = (state_ff == ST_EVAL) && !status.stall;
   assign cmd.sweep  = (state_ff == ST_SWEEP);

endmodule

/* rtl/cmc_dp.sv */
// Datapath: literal decode, polarity store, checker state and result register.
// Depends on cmc_pkg and cmc_ram.
module cmc_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  cmc_pkg::cmd_type                 cmd,
   output cmc_pkg::status_type              status,
   input  logic [1:0]                       req_op,
   input  logic signed [cmc_pkg::LIT_W-1:0] req_literal,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_clause_satisfied,
   output logic                             rsp_all_satisfied,
   output logic                             rsp_var_missing,
   output logic [cmc_pkg::NUM_W-1:0]        rsp_clause_number
);

   // request decode
   logic [cmc_pkg::LIT_W-1:0] lit_raw;
   logic [cmc_pkg::VAR_W-1:0] dec_var;
   cmc_pkg::pol_type          dec_pol;

   assign lit_raw = req_literal;

   always_comb begin
      if (lit_raw[cmc_pkg::LIT_W-1]) begin
         dec_var = cmc_pkg::VAR_W'({cmc_pkg::LIT_W{1'b0}} - lit_raw);
         dec_pol = cmc_pkg::POL_NEG;
      end else begin
         dec_var = cmc_pkg::VAR_W'(lit_raw);
         dec_pol = (lit_raw == '0) ? cmc_pkg::POL_UNDEF : cmc_pkg::POL_POS;
      end
   end

   // held request
   cmc_pkg::op_type           op_ff;
   logic [cmc_pkg::VAR_W-1:0] var_ff;
   cmc_pkg::pol_type          pol_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= cmc_pkg::op_type'(req_op);
         var_ff <= dec_var;
         pol_ff <= dec_pol;
      end
   end

   // polarity store
   logic [cmc_pkg::ADDR_W-1:0] clr_ff;
   logic                       ram_we;
   logic [cmc_pkg::ADDR_W-1:0] ram_waddr;
   cmc_pkg::pol_type           ram_wdata;
   cmc_pkg::pol_type           ram_rdata;
   logic                       var_in_store;

   assign var_in_store = 32'(var_ff) < 32'(cmc_pkg::MAX_VARS);

   always_comb begin
      ram_we    = cmd.sweep ||
                  (cmd.commit && (op_ff == cmc_pkg::OP_LOAD) && var_in_store);
      ram_waddr = cmd.sweep ? clr_ff : cmc_pkg::ADDR_W'(var_ff);
      ram_wdata = cmd.sweep ? cmc_pkg::POL_UNDEF : pol_ff;
   end

   cmc_ram #(
      .WIDTH (cmc_pkg::POL_W),
      .DEPTH (cmc_pkg::MAX_VARS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.accept),
      .raddr (cmc_pkg::ADDR_W'(dec_var)),
      .rdata (ram_rdata)
   );

   // checker state
   logic [cmc_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      open_ff, open_in;
   logic                      hit_ff, hit_in;
   logic                      ok_ff, ok_in;
   logic                      abort_ff, abort_in;
   logic [cmc_pkg::NUM_W-1:0] num_ff, num_in;

   logic                      emit;
   logic                      out_sat, out_all, out_miss;
   logic                      var_in_model;

   assign var_in_model = 32'(var_ff) < 32'(count_ff);

   always_comb begin
      count_in = count_ff;
      open_in  = open_ff;
      hit_in   = hit_ff;
      ok_in    = ok_ff;
      abort_in = abort_ff;
      num_in   = num_ff;
      emit     = 1'b0;
      out_sat  = 1'b0;
      out_all  = 1'b0;
      out_miss = 1'b0;
      unique case (op_ff)
         cmc_pkg::OP_LOAD: begin
            if (32'(count_ff) < 32'(cmc_pkg::MAX_VARS)) begin
               count_in = count_ff + 1'b1;
            end
         end
         cmc_pkg::OP_CLEAR: begin
            count_in = '0;
            open_in  = 1'b0;
            hit_in   = 1'b0;
            ok_in    = 1'b1;
            abort_in = 1'b0;
            num_in   = '0;
         end
         cmc_pkg::OP_CLAUSE: begin
            if (!abort_ff) begin
               if (pol_ff == cmc_pkg::POL_UNDEF) begin
                  // clause end; an empty clause is dropped
                  if (open_ff) begin
                     emit    = 1'b1;
                     out_sat = hit_ff;
                     out_all = ok_ff && hit_ff;
                     ok_in   = ok_ff && hit_ff;
                     open_in = 1'b0;
                     hit_in  = 1'b0;
                     if (num_ff != cmc_pkg::NUM_MAX) begin
                        num_in = num_ff + 1'b1;
                     end
                  end
               end else begin
                  open_in = 1'b1;
                  if (!hit_ff) begin
                     if (!var_in_model || !var_in_store) begin
                        emit     = 1'b1;
                        out_miss = 1'b1;
                        abort_in = 1'b1;
                        ok_in    = 1'b0;
                        open_in  = 1'b0;
                        hit_in   = 1'b0;
                     end else if (ram_rdata == pol_ff) begin
                        hit_in = 1'b1;
                     end
                  end
               end
            end
         end
         cmc_pkg::OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         open_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         ok_ff    <= 1'b1;
         abort_ff <= 1'b0;
         num_ff   <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         open_ff  <= open_in;
         hit_ff   <= hit_in;
         ok_ff    <= ok_in;
         abort_ff <= abort_in;
         num_ff   <= num_in;
      end
   end

   // clearing pass address
   assign status.sweep_done = clr_ff == cmc_pkg::ADDR_W'(cmc_pkg::MAX_VARS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.sweep) begin
         clr_ff <= status.sweep_done ? '0 : clr_ff + 1'b1;
      end
   end

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_sat_ff, rsp_all_ff, rsp_miss_ff;
   logic [cmc_pkg::NUM_W-1:0] rsp_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && emit) begin
         rsp_sat_ff  <= out_sat;
         rsp_all_ff  <= out_all;
         rsp_miss_ff <= out_miss;
         rsp_num_ff  <= num_ff;
      end
   end

   assign status.stall   = emit && rsp_valid_ff && !rsp_ready;
   assign status.restart = (op_ff == cmc_pkg::OP_CLEAR);

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_clause_satisfied = rsp_sat_ff;
   assign rsp_all_satisfied    = rsp_all_ff;
   assign rsp_var_missing      = rsp_miss_ff;
   assign rsp_clause_number    = rsp_num_ff;

endmodule

/* rtl/cnf_model_checker.sv */
// CNF model checker top level: joins the controller and the datapath.
// Depends on cmc_pkg, cmc_ctrl and cmc_dp.
//
// The accept cycle of a request launches the read of the polarity store,
// and the next cycle evaluates against the registered read data and
// commits, unless the output stalls. One request is in flight at a time;
// the result register lets the next request be accepted while a result
// still waits. A request that produces a result while the previous one is
// still untaken holds in evaluation until the output frees. After reset and
// after every clear request (op 2) the store is swept to UNDEF one entry per
// cycle, all 4096 entries, with req_ready low.
module cnf_model_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  logic signed [cmc_pkg::LIT_W-1:0] req_literal,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_clause_satisfied,
   output logic                             rsp_all_satisfied,
   output logic                             rsp_var_missing,
   output logic [cmc_pkg::NUM_W-1:0]        rsp_clause_number
);

   cmc_pkg::cmd_type    cmd;
   cmc_pkg::status_type status;

   cmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cmc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_op               (req_op),
      .req_literal          (req_literal),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_clause_satisfied (rsp_clause_satisfied),
      .rsp_all_satisfied    (rsp_all_satisfied),
      .rsp_var_missing      (rsp_var_missing),
      .rsp_clause_number    (rsp_clause_number)
   );

endmodule

/* rtl/cmc_checker.sv */
// Port-level assertions for the CNF model checker, bound to the top level.
// Depends on cmc_pkg and cnf_model_checker.
module cmc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_clause_satisfied,
   input logic                      rsp_all_satisfied,
   input logic                      rsp_var_missing,
   input logic [cmc_pkg::NUM_W-1:0] rsp_clause_number
);

   // store sweep follows reset, so no request is taken right after it
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // one request in flight at a time
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one still in flight");

   a_missing_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_var_missing) |-> (!rsp_clause_satisfied && !rsp_all_satisfied))
      else $error("missing-variable result reports a satisfied flag");

   a_all_implies_clause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_all_satisfied) |-> rsp_clause_satisfied)
      else $error("all_satisfied set on an unsatisfied clause");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_clause_number)))
      else $error("result dropped or changed while stalled");

endmodule

bind cnf_model_checker cmc_checker u_cmc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_clause_satisfied (rsp_clause_satisfied),
   .rsp_all_satisfied    (rsp_all_satisfied),
   .rsp_var_missing      (rsp_var_missing),
   .rsp_clause_number    (rsp_clause_number)
);
